>>> design/uvs_pkg.sv
// Package for the UV-sphere vertex generator: widths, types, the arctangent
// table and the saturation helpers. No dependencies.
package uvs_pkg;

   localparam int CountWidth  = 11;
   localparam int RadiusWidth = 16;
   localparam int MaxSegments = 1024;
   localparam int DivSteps    = 33;
   localparam int CordicSteps = 16;
   localparam int CordicWidth = 18;
   localparam int AngleWidth  = 33;

   localparam logic [1:0] CsrRingCount   = 2'd0;
   localparam logic [1:0] CsrSectorCount = 2'd1;
   localparam logic [1:0] CsrRadius      = 2'd2;

   // CORDIC start value: reciprocal of the gain, rounded into Q15
   localparam logic signed [CordicWidth-1:0] CordicInit = 18'sd19898;

   // one long-division digit cell: partial remainder, pending numerator bits,
   // quotient bits so far
   typedef struct packed {
      logic [CountWidth-1:0] rem;
      logic [DivSteps-1:0]   low;
      logic [DivSteps-1:0]   quot;
   } div_type;

   typedef struct packed {
      logic signed [CordicWidth-1:0] x;
      logic signed [CordicWidth-1:0] y;
      logic signed [AngleWidth-1:0]  z;
      logic                          flip;
   } cordic_type;

   // arctangent of 2^-i, 2^32 per turn
   localparam logic [31:0] AtanTurns [CordicSteps] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861
   };

   function automatic logic signed [15:0] sat_q15(input logic signed [CordicWidth-1:0] v);
      logic signed [15:0] r;
      if (v > 18'sd32767) r = 16'sd32767;
      else if (v < -18'sd32768) r = -16'sd32768;
      else r = v[15:0];
      return r;
   endfunction

   // round a Q30 product back to Q15 and clamp
   function automatic logic signed [15:0] mul_q15(input logic signed [15:0] a,
                                                   input logic signed [15:0] b);
      logic signed [31:0] p;
      logic signed [32:0] t;
      logic signed [17:0] s;
      p = a * b;
      t = {p[31], p} + 33'sd16384;
      s = t[32:15];
      return sat_q15(s);
   endfunction

   // normal (Q1.15) times radius (Q8.8), rounded to Q8.8, clamped to 17 bits
   function automatic logic signed [16:0] scale_pos(input logic signed [15:0] n,
                                                     input logic [RadiusWidth-1:0] rad);
      logic signed [32:0] p;
      logic signed [33:0] t;
      logic signed [18:0] s;
      logic signed [16:0] r;
      p = n * $signed({1'b0, rad});
      t = {p[32], p} + 34'sd16384;
      s = t[33:15];
      if (s > 19'sd65535) r = 17'sd65535;
      else if (s < -19'sd65536) r = -17'sd65536;
      else r = s[16:0];
      return r;
   endfunction

endpackage

>>> design/uvs_div_cell.sv
// One restoring-division digit cell of the quotient chain.
// Depends on uvs_pkg.
module uvs_div_cell (
   input  logic                              clock,
   input  logic [uvs_pkg::CountWidth-1:0]    divisor,
   input  uvs_pkg::div_type                  stage_in,
   output uvs_pkg::div_type                  stage_out
);
   uvs_pkg::div_type stage_ff, stage_in_next;
   logic [uvs_pkg::CountWidth:0] trial;
   logic                         take;

   always_comb begin
      trial = {stage_in.rem, stage_in.low[uvs_pkg::DivSteps-1]};
      take  = trial >= {1'b0, divisor};
      stage_in_next.rem  = take ? (trial[uvs_pkg::CountWidth-1:0] - divisor)
                                : trial[uvs_pkg::CountWidth-1:0];
      stage_in_next.low  = {stage_in.low[uvs_pkg::DivSteps-2:0], 1'b0};
      stage_in_next.quot = {stage_in.quot[uvs_pkg::DivSteps-2:0], take};
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in_next;
   end

   assign stage_out = stage_ff;
endmodule

>>> design/uvs_cordic_cell.sv
// One CORDIC rotation cell; the step number sets shift and arctangent.
// Depends on uvs_pkg.
module uvs_cordic_cell (
   input  logic                 clock,
   input  logic [3:0]           step,
   input  uvs_pkg::cordic_type  stage_in,
   output uvs_pkg::cordic_type  stage_out
);
   uvs_pkg::cordic_type stage_ff, stage_in_next;
   logic signed [uvs_pkg::CordicWidth-1:0] xs, ys;
   logic signed [uvs_pkg::AngleWidth-1:0]  atan;

   always_comb begin
      xs   = stage_in.x >>> step;
      ys   = stage_in.y >>> step;
      atan = $signed({1'b0, uvs_pkg::AtanTurns[step]});
      stage_in_next.flip = stage_in.flip;
      if (!stage_in.z[uvs_pkg::AngleWidth-1]) begin
         stage_in_next.x = stage_in.x - ys;
         stage_in_next.y = stage_in.y + xs;
         stage_in_next.z = stage_in.z - atan;
      end else begin
         stage_in_next.x = stage_in.x + ys;
         stage_in_next.y = stage_in.y - xs;
         stage_in_next.z = stage_in.z + atan;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in_next;
   end

   assign stage_out = stage_ff;
endmodule

>>> design/uv_sphere_vertex_generator.sv
// Top level of the UV-sphere vertex generator: division chains, CORDIC
// chains, normal and position stages. Depends on uvs_pkg, uvs_div_cell,
// uvs_cordic_cell.
//
//   channel  direction  handshake              payload
//   req      in         start & !busy          ring_index, sector_index
//   rsp      out        rsp_valid (one cycle)  normals, positions, tex coords
//   csr      in         csr_write_enable       csr_index, csr_write_data
//
// One vertex per clock through 1 input stage, 33 division digit
// cells (one quotient bit each), 16 CORDIC rotation cells, then flip/clamp,
// normal products and position scaling. busy is always low.
// Reset (synchronous) clears the valid line and loads the default counts
// and radius. The receiver cannot stall; nothing stalls inside.
module uv_sphere_vertex_generator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [10:0]                          req_ring_index,
   input  logic [10:0]                          req_sector_index,
   output logic                                 rsp_valid,
   output logic signed [15:0]                   rsp_normal_x,
   output logic signed [15:0]                   rsp_normal_y,
   output logic signed [15:0]                   rsp_normal_z,
   output logic signed [16:0]                   rsp_pos_x,
   output logic signed [16:0]                   rsp_pos_y,
   output logic signed [16:0]                   rsp_pos_z,
   output logic [16:0]                          rsp_tex_u,
   output logic [16:0]                          rsp_tex_v,
   input  logic                                 csr_write_enable,
   input  logic [1:0]                           csr_index,
   input  logic [15:0]                          csr_write_data
);
   localparam int Latency = 1 + uvs_pkg::DivSteps + uvs_pkg::CordicSteps + 3;
   localparam int TexDelay = uvs_pkg::CordicSteps + 3;

   logic [10:0] ring_count_ff, sector_count_ff;
   logic [15:0] radius_ff;
   logic [10:0] rings, sectors, r_clip, s_clip;
   logic [9:0]  h_r, h_s;
   logic        valid_ff [Latency];

   uvs_pkg::div_type pol_st [uvs_pkg::DivSteps+1];
   uvs_pkg::div_type az_st  [uvs_pkg::DivSteps+1];
   uvs_pkg::div_type u_st   [uvs_pkg::DivSteps+1];
   uvs_pkg::div_type v_st   [uvs_pkg::DivSteps+1];
   uvs_pkg::div_type pol_in, az_in, u_in, v_in;

   uvs_pkg::cordic_type pc_st [uvs_pkg::CordicSteps+1];
   uvs_pkg::cordic_type ac_st [uvs_pkg::CordicSteps+1];

   logic [16:0] tex_u_ff [TexDelay];
   logic [16:0] tex_v_ff [TexDelay];

   logic signed [15:0] sp_ff, cp_ff, sa_ff, ca_ff;
   logic signed [15:0] nx_ff, ny_ff, nz_ff;
   logic signed [16:0] px_ff, py_ff, pz_ff;

   assign busy = 1'b0;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_count_ff   <= 11'd16;
         sector_count_ff <= 11'd32;
         radius_ff       <= 16'd256;
      end else if (csr_write_enable) begin
         case (csr_index)
            uvs_pkg::CsrRingCount:   ring_count_ff   <= csr_write_data[10:0];
            uvs_pkg::CsrSectorCount: sector_count_ff <= csr_write_data[10:0];
            uvs_pkg::CsrRadius:      radius_ff       <= csr_write_data;
            default: ;
         endcase
      end
   end

   // effective counts and clipped indices
   always_comb begin
      rings   = (ring_count_ff == 11'd0) ? 11'd1 :
                (ring_count_ff > 11'(uvs_pkg::MaxSegments)) ? 11'(uvs_pkg::MaxSegments)
                                                            : ring_count_ff;
      sectors = (sector_count_ff == 11'd0) ? 11'd1 :
                (sector_count_ff > 11'(uvs_pkg::MaxSegments)) ? 11'(uvs_pkg::MaxSegments)
                                                              : sector_count_ff;
      r_clip = (req_ring_index > rings) ? rings : req_ring_index;
      s_clip = (req_sector_index > sectors) ? sectors : req_sector_index;
      h_r = rings[10:1];
      h_s = sectors[10:1];
      // numerator split: angle tops preload the remainder, 33 low bits feed cells
      pol_in.rem  = {2'b0, r_clip[10:2]};
      pol_in.low  = {r_clip[1:0], 21'd0, h_r};
      pol_in.quot = '0;
      az_in.rem   = {1'b0, s_clip[10:1]};
      az_in.low   = {s_clip[0], 22'd0, h_s};
      az_in.quot  = '0;
      u_in.rem    = '0;
      u_in.low    = {6'd0, s_clip, 6'd0, h_s};
      u_in.quot   = '0;
      v_in.rem    = '0;
      v_in.low    = {6'd0, r_clip, 6'd0, h_r};
      v_in.quot   = '0;
   end

   always_ff @(posedge clock) begin
      pol_st[0] <= pol_in;
      az_st[0]  <= az_in;
      u_st[0]   <= u_in;
      v_st[0]   <= v_in;
   end

   // valid line follows the data through every stage
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Latency; i++) valid_ff[i] <= 1'b0;
      end else begin
         valid_ff[0] <= start;
         for (int i = 1; i < Latency; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   genvar g;
   generate
      for (g = 0; g < uvs_pkg::DivSteps; g++) begin : g_div
         uvs_div_cell u_pol (.clock(clock), .divisor(rings),
                             .stage_in(pol_st[g]), .stage_out(pol_st[g+1]));
         uvs_div_cell u_az  (.clock(clock), .divisor(sectors),
                             .stage_in(az_st[g]), .stage_out(az_st[g+1]));
         uvs_div_cell u_tu  (.clock(clock), .divisor(sectors),
                             .stage_in(u_st[g]), .stage_out(u_st[g+1]));
         uvs_div_cell u_tv  (.clock(clock), .divisor(rings),
                             .stage_in(v_st[g]), .stage_out(v_st[g+1]));
      end
   endgenerate

   // quadrant fold: angles in the left half are turned by a half turn
   function automatic uvs_pkg::cordic_type cordic_start(input logic [31:0] angle);
      uvs_pkg::cordic_type c;
      logic [31:0] a;
      c.flip = angle[31] ^ angle[30];
      a = c.flip ? {~angle[31], angle[30:0]} : angle;
      c.z = $signed({a[31], a});
      c.x = uvs_pkg::CordicInit;
      c.y = '0;
      return c;
   endfunction

   assign pc_st[0] = cordic_start(pol_st[uvs_pkg::DivSteps].quot[31:0]);
   assign ac_st[0] = cordic_start(az_st[uvs_pkg::DivSteps].quot[31:0]);

   generate
      for (g = 0; g < uvs_pkg::CordicSteps; g++) begin : g_cordic
         uvs_cordic_cell u_pc (.clock(clock), .step(4'(g)),
                               .stage_in(pc_st[g]), .stage_out(pc_st[g+1]));
         uvs_cordic_cell u_ac (.clock(clock), .step(4'(g)),
                               .stage_in(ac_st[g]), .stage_out(ac_st[g+1]));
      end
   endgenerate

   // texture coordinates ride alongside the trig stages
   always_ff @(posedge clock) begin
      tex_u_ff[0] <= u_st[uvs_pkg::DivSteps].quot[16:0];
      tex_v_ff[0] <= v_st[uvs_pkg::DivSteps].quot[16:0];
      for (int i = 1; i < TexDelay; i++) begin
         tex_u_ff[i] <= tex_u_ff[i-1];
         tex_v_ff[i] <= tex_v_ff[i-1];
      end
   end

   // undo the fold and clamp, then products, then position
   always_ff @(posedge clock) begin
      sp_ff <= uvs_pkg::sat_q15(pc_st[uvs_pkg::CordicSteps].flip ?
                                -pc_st[uvs_pkg::CordicSteps].y : pc_st[uvs_pkg::CordicSteps].y);
      cp_ff <= uvs_pkg::sat_q15(pc_st[uvs_pkg::CordicSteps].flip ?
                                -pc_st[uvs_pkg::CordicSteps].x : pc_st[uvs_pkg::CordicSteps].x);
      sa_ff <= uvs_pkg::sat_q15(ac_st[uvs_pkg::CordicSteps].flip ?
                                -ac_st[uvs_pkg::CordicSteps].y : ac_st[uvs_pkg::CordicSteps].y);
      ca_ff <= uvs_pkg::sat_q15(ac_st[uvs_pkg::CordicSteps].flip ?
                                -ac_st[uvs_pkg::CordicSteps].x : ac_st[uvs_pkg::CordicSteps].x);
      nx_ff <= uvs_pkg::mul_q15(ca_ff, sp_ff);
      ny_ff <= cp_ff;
      nz_ff <= uvs_pkg::mul_q15(sa_ff, sp_ff);
      px_ff <= uvs_pkg::scale_pos(nx_ff, radius_ff);
      py_ff <= uvs_pkg::scale_pos(ny_ff, radius_ff);
      pz_ff <= uvs_pkg::scale_pos(nz_ff, radius_ff);
      rsp_normal_x <= nx_ff;
      rsp_normal_y <= ny_ff;
      rsp_normal_z <= nz_ff;
   end

   assign rsp_valid = valid_ff[Latency-1];
   assign rsp_pos_x = px_ff;
   assign rsp_pos_y = py_ff;
   assign rsp_pos_z = pz_ff;
   assign rsp_tex_u = tex_u_ff[TexDelay-1];
   assign rsp_tex_v = tex_v_ff[TexDelay-1];
endmodule

>>> design/uvs_checker.sv
// Port-level checks for the UV-sphere vertex generator, bound to the top.
// Depends on uv_sphere_vertex_generator ports only.
module uvs_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [16:0] rsp_tex_u,
   input logic [16:0] rsp_tex_v
);
   a_no_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##53 rsp_valid)
      else $error("result missing after transfer");
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      !start |-> ##53 !rsp_valid)
      else $error("result without transfer");
   a_tex_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_tex_u <= 17'd65536) && (rsp_tex_v <= 17'd65536))
      else $error("texture coordinate out of range");
endmodule

bind uv_sphere_vertex_generator uvs_checker u_uvs_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_tex_u(rsp_tex_u), .rsp_tex_v(rsp_tex_v)
);

>>> dv/uvs_vertex_checker.sv
// Scoreboard for the UV-sphere vertex generator: predicts each vertex from the
// request transfer and the register writes it sees, then compares. Needs uvs_pkg.
`timescale 1ns / 100ps
module uvs_vertex_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic [10:0]         req_ring_index,
   input  logic [10:0]         req_sector_index,
   input  logic                rsp_valid,
   input  logic signed [15:0]  rsp_normal_x,
   input  logic signed [15:0]  rsp_normal_y,
   input  logic signed [15:0]  rsp_normal_z,
   input  logic signed [16:0]  rsp_pos_x,
   input  logic signed [16:0]  rsp_pos_y,
   input  logic signed [16:0]  rsp_pos_z,
   input  logic [16:0]         rsp_tex_u,
   input  logic [16:0]         rsp_tex_v,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_write_data,
   output int                  vertices_pending,
   output int                  failures
);
   typedef logic [7:0][16:0] vertex_type;

   logic [10:0] rings_reg, sectors_reg;
   logic [15:0] radius_reg;
   vertex_type  vertex_queue[$];

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint eff_count(input logic [10:0] c);
      if (c == 0) return 1;
      if (c > uvs_pkg::MaxSegments) return uvs_pkg::MaxSegments;
      return c;
   endfunction

   // CORDIC on a binary angle (2^32 per turn), results in Q1.15
   function automatic void sin_cos(input logic [31:0] ang, output longint s_out,
                                   output longint c_out);
      logic [31:0] t;
      int          zi;
      longint      x, y, z, xs, ys;
      bit          flip;
      t = ang + 32'h4000_0000;
      flip = t[31];
      if (flip) ang = ang + 32'h8000_0000;
      zi = ang;
      z = zi;
      x = uvs_pkg::CordicInit;
      y = 0;
      for (int i = 0; i < uvs_pkg::CordicSteps; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= longint'(uvs_pkg::AtanTurns[i]);
         end else begin
            x += ys; y -= xs; z += longint'(uvs_pkg::AtanTurns[i]);
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      s_out = clamp(y, -32768, 32767);
      c_out = clamp(x, -32768, 32767);
   endfunction

   function automatic longint product_q15(input longint a, input longint b);
      return clamp((a * b + 16384) >>> 15, -32768, 32767);
   endfunction

   function automatic longint scaled(input longint n);
      return clamp((n * longint'(radius_reg) + 16384) >>> 15, -65536, 65535);
   endfunction

   function automatic vertex_type predict_vertex(input logic [10:0] ri, input logic [10:0] si);
      longint unsigned rings, sectors, r, s, pol64, az64;
      longint          sp, cp, sa, ca, nx, ny, nz;
      vertex_type      v;
      rings = eff_count(rings_reg);
      sectors = eff_count(sectors_reg);
      r = ri > rings ? rings : ri;
      s = si > sectors ? sectors : si;
      pol64 = (r * 64'h8000_0000 + rings / 2) / rings;
      az64 = ((s << 32) + sectors / 2) / sectors;
      sin_cos(pol64[31:0], sp, cp);
      sin_cos(az64[31:0], sa, ca);
      nx = product_q15(ca, sp);
      ny = cp;
      nz = product_q15(sa, sp);
      v[0] = {1'b0, nx[15:0]};
      v[1] = {1'b0, ny[15:0]};
      v[2] = {1'b0, nz[15:0]};
      v[3] = 17'(scaled(nx));
      v[4] = 17'(scaled(ny));
      v[5] = 17'(scaled(nz));
      v[6] = 17'((s * 65536 + sectors / 2) / sectors);
      v[7] = 17'((r * 65536 + rings / 2) / rings);
      return v;
   endfunction

   string field_names[8] = '{"normal_x", "normal_y", "normal_z", "pos_x", "pos_y", "pos_z",
                              "tex_u", "tex_v"};

   always @(posedge clock) begin
      vertex_type got, want;
      if (reset) begin
         rings_reg <= 11'd16;
         sectors_reg <= 11'd32;
         radius_reg <= 16'd256;
         vertices_pending <= 0;
         failures <= 0;
         vertex_queue.delete();
      end else begin
         if (start && !busy)
            vertex_queue.insert(vertex_queue.size(),
                                predict_vertex(req_ring_index, req_sector_index));
         if (rsp_valid) begin
            got = {rsp_tex_v, rsp_tex_u, rsp_pos_z, rsp_pos_y, rsp_pos_x,
                   {1'b0, rsp_normal_z}, {1'b0, rsp_normal_y}, {1'b0, rsp_normal_x}};
            if (vertex_queue.size() == 0) begin
               $error("vertex transfer with nothing expected");
               failures <= failures + 1;
            end else begin
               want = vertex_queue.pop_front();
               if (got != want) begin
                  failures <= failures + 1;
                  for (int i = 0; i < 8; i++)
                     if (got[i] !== want[i])
                        $error("%s: expected %h, got %h", field_names[i], want[i], got[i]);
               end
            end
         end
         vertices_pending <= vertex_queue.size();
         if (csr_write_enable) begin
            case (csr_index)
               uvs_pkg::CsrRingCount: begin
                  rings_reg <= csr_write_data[10:0];
               end
               uvs_pkg::CsrSectorCount: begin
                  sectors_reg <= csr_write_data[10:0];
               end
               uvs_pkg::CsrRadius: begin
                  radius_reg <= csr_write_data;
               end
               default: begin
               end
            endcase
         end
      end
   end

endmodule

>>> dv/uv_sphere_vertex_generator_tb.sv
// Testbench top for the UV-sphere vertex generator: clock, reset, stimulus
// over several register settings, watchdog and verdict. Needs uvs_pkg,
// uvs_vertex_checker and the block.
`timescale 1ns / 100ps
module uv_sphere_vertex_generator_tb;

   localparam int IdleCycles = 60;     // pipeline is 53 deep
   localparam int WatchLimit = 3000;   // cycles without any transfer

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [10:0]        req_ring_index = '0;
   logic [10:0]        req_sector_index = '0;
   logic               rsp_valid;
   logic signed [15:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic signed [16:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic [16:0]        rsp_tex_u, rsp_tex_v;
   logic               csr_write_enable = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [15:0]        csr_write_data = '0;
   int                 vertices_pending, failures;
   int                 quiet_cycles = 0;
   logic [10:0]        rings_now = 11'd16, sectors_now = 11'd32;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   uv_sphere_vertex_generator u_top (.*);
   uvs_vertex_checker u_checker (.*);

   // watchdog: any transfer on either channel keeps it quiet
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // one register write with one cycle of write enable; the enable drops before the task returns
   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == uvs_pkg::CsrRingCount) rings_now = val[10:0];
      if (idx == uvs_pkg::CsrSectorCount) sectors_now = val[10:0];
      @(negedge clock);
   endtask

   // hold off until every vertex is back, then let the pipe drain
   task automatic drain();
      while (vertices_pending != 0) @(negedge clock);
      repeat (IdleCycles) @(negedge clock);
   endtask

   // one request transfer, after a random gap when gaps is set; start stays up for back-to-back
   task automatic send_vertex(input logic [10:0] ri, input logic [10:0] si, input bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 4) : 0;
      repeat (gap) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_ring_index <= ri;
      req_sector_index <= si;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // index mostly up to one past the grid edge, sometimes anywhere in the field
   function automatic logic [10:0] pick_index(input logic [10:0] count);
      int lim;
      lim = count == 0 ? 1 : (count > uvs_pkg::MaxSegments ? uvs_pkg::MaxSegments : count);
      if ($urandom_range(0, 4) == 0) return 11'($urandom_range(0, 2047));
      return 11'($urandom_range(0, lim + 1));
   endfunction

   task automatic random_vertices(input int n);
      bit gaps;
      for (int i = 0; i < n; i++) begin
         if (i % 20 == 0) gaps = $urandom_range(0, 2) != 0;  // some bursts with no gaps
         send_vertex(pick_index(rings_now), pick_index(sectors_now), gaps);
      end
      start <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: poles, seam, equator, out-of-range indices
      send_vertex(11'd0, 11'd0, 1'b0);
      send_vertex(11'd16, 11'd32, 1'b0);
      send_vertex(11'd8, 11'd8, 1'b1);
      send_vertex(11'd4, 11'd16, 1'b0);
      send_vertex(11'd12, 11'd24, 1'b1);
      send_vertex(11'd2047, 11'd2047, 1'b0);
      send_vertex(11'd17, 11'd33, 1'b0);
      send_vertex(11'd0, 11'd2047, 1'b1);
      send_vertex(11'd1365, 11'd682, 1'b0);
      random_vertices(50);
      drain();

      // single band and slice, full radius; a write to an unused index
      write_reg(uvs_pkg::CsrRingCount, 16'd1);
      write_reg(uvs_pkg::CsrSectorCount, 16'd1);
      write_reg(uvs_pkg::CsrRadius, 16'hFFFF);
      write_reg(2'd3, 16'hFFFF);
      send_vertex(11'd1, 11'd1, 1'b0);
      send_vertex(11'd0, 11'd0, 1'b0);
      random_vertices(40);
      drain();

      // largest grid, zero radius
      write_reg(uvs_pkg::CsrRingCount, 16'd1024);
      write_reg(uvs_pkg::CsrSectorCount, 16'd1024);
      write_reg(uvs_pkg::CsrRadius, 16'd0);
      send_vertex(11'd1024, 11'd1024, 1'b0);
      send_vertex(11'd512, 11'd256, 1'b0);
      send_vertex(11'd1023, 11'd1, 1'b0);
      random_vertices(60);
      drain();

      // zero count acts as one, oversized count clamps
      write_reg(uvs_pkg::CsrRingCount, 16'd0);
      write_reg(uvs_pkg::CsrSectorCount, 16'hF7FF);
      write_reg(uvs_pkg::CsrRadius, 16'hA5A5);
      send_vertex(11'd1, 11'd1025, 1'b0);
      random_vertices(60);
      drain();

      write_reg(uvs_pkg::CsrRingCount, 16'd2047);
      write_reg(uvs_pkg::CsrSectorCount, 16'd0);
      write_reg(uvs_pkg::CsrRadius, 16'h8000);
      random_vertices(60);
      drain();

      // a few random settings to finish
      for (int p = 0; p < 4; p++) begin
         write_reg(uvs_pkg::CsrRingCount, 16'($urandom_range(1, 1100)));
         write_reg(uvs_pkg::CsrSectorCount, 16'($urandom_range(1, 1100)));
         write_reg(uvs_pkg::CsrRadius, 16'($urandom_range(0, 65535)));
         random_vertices(45);
         drain();
      end

      if (failures == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule
